[hdl/hwt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared types and constants for the world transform update block.
// ----------------------------------------------------------------------------
package hwt_pkg;

    localparam int NODE_W    = 8;
    localparam int MAX_NODES = 256;
    localparam int CNT_W     = 9;
    localparam int LVL_W     = 4;
    localparam int ELEM_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = NODE_W + ELEM_W;
    localparam int ENTRY_W   = 1 + NODE_W + LVL_W;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 50;

    localparam logic [1:0] OP_SET_HIER = 2'd0;
    localparam logic [1:0] OP_WR_LOCAL = 2'd1;
    localparam logic [1:0] OP_UPDATE   = 2'd2;
    localparam logic [1:0] OP_RD_WORLD = 2'd3;

    typedef struct packed {
        logic [1:0]               operation;
        logic [NODE_W-1:0]        node;
        logic [NODE_W-1:0]        parent_node;
        logic                     has_parent;
        logic [LVL_W-1:0]         node_level;
        logic [ELEM_W-1:0]        element;
        logic signed [DATA_W-1:0] element_value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     saturated;
    } out_t;

    typedef struct packed {
        logic                     valid;
        logic [ELEM_W-1:0]        elem;
        logic signed [DATA_W-1:0] data;
    } hwt_wr_t;

endpackage
`default_nettype wire

[hdl/hwt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_ram
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
module hwt_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[hdl/hwt_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_mac
// Q16.16 multiply-accumulate with floor truncation and saturating result.
// ----------------------------------------------------------------------------
module hwt_mac (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    input  wire logic signed [hwt_pkg::DATA_W-1:0] a,
    input  wire logic signed [hwt_pkg::DATA_W-1:0] b,
    input  wire logic                            first,
    input  wire logic                            last,
    input  wire logic [hwt_pkg::ELEM_W-1:0]      elem,
    output hwt_pkg::hwt_wr_t                     wr,
    output logic                                 sat,
    output logic                                 busy
);

    logic                                prod_v_reg;
    logic                                prod_first_reg;
    logic                                prod_last_reg;
    logic [hwt_pkg::ELEM_W-1:0]          prod_elem_reg;
    logic signed [hwt_pkg::PROD_W-1:0]   prod_reg;
    logic signed [hwt_pkg::ACC_W-1:0]    acc_reg;
    logic signed [2*hwt_pkg::DATA_W-1:0] full_prod;
    logic signed [hwt_pkg::ACC_W-1:0]    acc_next;
    logic signed [hwt_pkg::ACC_W-1:0]    max_v;
    logic signed [hwt_pkg::ACC_W-1:0]    min_v;

    assign full_prod = a * b;
    assign max_v = hwt_pkg::ACC_W'(64'sh0000_0000_7FFF_FFFF);
    assign min_v = hwt_pkg::ACC_W'(-64'sh0000_0000_8000_0000);

    always_comb begin
        acc_next = (prod_first_reg ? '0 : acc_reg)
                 + hwt_pkg::ACC_W'(prod_reg);
        wr.valid = prod_v_reg && prod_last_reg;
        wr.elem  = prod_elem_reg;
        sat      = 1'b0;
        if (acc_next > max_v) begin
            wr.data = 32'sh7FFF_FFFF;
            sat     = wr.valid;
        end else if (acc_next < min_v) begin
            wr.data = -32'sh8000_0000;
            sat     = wr.valid;
        end else begin
            wr.data = acc_next[hwt_pkg::DATA_W-1:0];
        end
    end

    assign busy = prod_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_first_reg <= first;
        prod_last_reg  <= last;
        prod_elem_reg  <= elem;
        prod_reg       <= full_prod[2*hwt_pkg::DATA_W-1:16];
        if (prod_v_reg) begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

[hdl/hierarchy_world_transform_update.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchy_world_transform_update
// Scene hierarchy world matrix unit in Q16.16 with a node table in RAM.
// ----------------------------------------------------------------------------
// Input transactions carry one of four operations; each returns exactly one
// output transaction. Set hierarchy and write local are committed in the
// accepting cycle and their zero result is presented on the next cycle. A
// world read passes through the registered read of the world RAM and the
// ST_RD state before its result is registered at the output.
// An update first scans the node table, one node per cycle, to find the top
// level in use. For each level 0..top it then walks all n nodes, reading
// each entry in ST_NRD and checking its level in ST_NCHK. A matching root
// copies its local matrix to the world store; a matching child loads its
// parent's world matrix into a 16-entry buffer and then runs 64
// multiply-accumulate steps through the single multiplier.
// Only one transaction is in flight. The block accepts a new transaction only
// when it is idle and the output register is empty or being drained, so a
// stalled receiver holds the input side off. The configuration register is
// written through cfg_we and cfg_data.
// Reset clears node_count and marks every node as a root at level zero with
// parent zero; the local and world stores are undefined until written.
// ----------------------------------------------------------------------------
module hierarchy_world_transform_update (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [hwt_pkg::CNT_W-1:0] cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire hwt_pkg::in_t             s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output hwt_pkg::out_t                 m_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_NRD   = 4'd3;
    localparam logic [3:0] ST_NCHK  = 4'd4;
    localparam logic [3:0] ST_COPY  = 4'd5;
    localparam logic [3:0] ST_PLOAD = 4'd6;
    localparam logic [3:0] ST_MAC   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [hwt_pkg::CNT_W-1:0]     node_count_reg;
    logic [hwt_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [hwt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [hwt_pkg::LVL_W-1:0]     top_reg, top_next;
    logic [hwt_pkg::LVL_W-1:0]     lvl_reg, lvl_next;
    logic [6:0]                    j_reg, j_next;
    logic                          pv_reg, pv_next;
    logic [hwt_pkg::ELEM_W-1:0]    pj_reg;
    logic [hwt_pkg::NODE_W-1:0]    parent_reg, parent_next;
    logic                          sat_reg, sat_next;
    logic                          m_valid_reg, m_valid_next;
    hwt_pkg::out_t                 m_data_reg, m_data_next;
    logic [hwt_pkg::DATA_W-1:0]    par_buf [0:15];
    logic                          mv_reg;
    logic [3:0]                    pidx_reg;
    logic [hwt_pkg::ELEM_W-1:0]    me_reg;
    logic                          mfirst_reg, mlast_reg;
    logic [hwt_pkg::MAX_NODES-1:0] nt_valid_reg;
    logic                          nt_vld_q_reg;

    logic                          accept;
    logic                          nt_we, nt_re;
    logic [hwt_pkg::NODE_W-1:0]    nt_raddr;
    logic [hwt_pkg::ENTRY_W-1:0]   nt_wdata, nt_rdata, entry;
    logic                          e_root;
    logic [hwt_pkg::NODE_W-1:0]    e_parent;
    logic [hwt_pkg::LVL_W-1:0]     e_level;
    logic                          lo_we, lo_re;
    logic [hwt_pkg::ADDR_W-1:0]    lo_raddr;
    logic [hwt_pkg::DATA_W-1:0]    lo_rdata;
    logic                          wo_we, wo_re;
    logic [hwt_pkg::ADDR_W-1:0]    wo_waddr, wo_raddr;
    logic [hwt_pkg::DATA_W-1:0]    wo_wdata, wo_rdata;
    logic                          mac_issue;
    hwt_pkg::hwt_wr_t              mac_wr;
    logic                          mac_sat, mac_busy;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign nt_we    = accept && (s_data.operation == hwt_pkg::OP_SET_HIER);
    assign nt_wdata = {!s_data.has_parent,
                       s_data.has_parent ? s_data.parent_node : {hwt_pkg::NODE_W{1'b0}},
                       s_data.node_level};
    assign entry    = nt_vld_q_reg ? nt_rdata
                                   : {1'b1, {hwt_pkg::NODE_W{1'b0}}, {hwt_pkg::LVL_W{1'b0}}};
    assign e_root   = entry[hwt_pkg::ENTRY_W-1];
    assign e_parent = entry[hwt_pkg::LVL_W +: hwt_pkg::NODE_W];
    assign e_level  = entry[hwt_pkg::LVL_W-1:0];

    hwt_ram #(.WIDTH(hwt_pkg::ENTRY_W), .ADDR_W(hwt_pkg::NODE_W)) u_node_ram (
        .aclk  (aclk),
        .we    (nt_we),
        .waddr (s_data.node),
        .wdata (nt_wdata),
        .re    (nt_re),
        .raddr (nt_raddr),
        .rdata (nt_rdata)
    );

    assign lo_we = accept && (s_data.operation == hwt_pkg::OP_WR_LOCAL);

    hwt_ram #(.WIDTH(hwt_pkg::DATA_W), .ADDR_W(hwt_pkg::ADDR_W)) u_local_ram (
        .aclk  (aclk),
        .we    (lo_we),
        .waddr ({s_data.node, s_data.element}),
        .wdata (s_data.element_value),
        .re    (lo_re),
        .raddr (lo_raddr),
        .rdata (lo_rdata)
    );

    hwt_ram #(.WIDTH(hwt_pkg::DATA_W), .ADDR_W(hwt_pkg::ADDR_W)) u_world_ram (
        .aclk  (aclk),
        .we    (wo_we),
        .waddr (wo_waddr),
        .wdata (wo_wdata),
        .re    (wo_re),
        .raddr (wo_raddr),
        .rdata (wo_rdata)
    );

    hwt_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (mv_reg),
        .a        (par_buf[pidx_reg]),
        .b        (lo_rdata),
        .first    (mfirst_reg),
        .last     (mlast_reg),
        .elem     (me_reg),
        .wr       (mac_wr),
        .sat      (mac_sat),
        .busy     (mac_busy)
    );

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        top_next     = top_reg;
        lvl_next     = lvl_reg;
        j_next       = j_reg;
        pv_next      = 1'b0;
        parent_next  = parent_reg;
        sat_next     = sat_reg | mac_sat;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        nt_re        = 1'b0;
        nt_raddr     = cnt_reg[hwt_pkg::NODE_W-1:0];
        lo_re        = 1'b0;
        lo_raddr     = {cnt_reg[hwt_pkg::NODE_W-1:0], j_reg[3:0]};
        wo_re        = 1'b0;
        wo_raddr     = {parent_reg, j_reg[3:0]};
        wo_we        = 1'b0;
        wo_waddr     = {cnt_reg[hwt_pkg::NODE_W-1:0], pj_reg};
        wo_wdata     = lo_rdata;
        mac_issue    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.operation)
                        hwt_pkg::OP_RD_WORLD: begin
                            wo_re      = 1'b1;
                            wo_raddr   = {s_data.node, s_data.element};
                            state_next = ST_RD;
                        end
                        hwt_pkg::OP_UPDATE: begin
                            n_next     = (node_count_reg > hwt_pkg::CNT_W'(hwt_pkg::MAX_NODES))
                                       ? hwt_pkg::CNT_W'(hwt_pkg::MAX_NODES) : node_count_reg;
                            cnt_next   = '0;
                            top_next   = '0;
                            sat_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                        end
                    endcase
                end
            end
            ST_RD: begin
                m_valid_next           = 1'b1;
                m_data_next.read_value = wo_rdata;
                m_data_next.saturated  = 1'b0;
                state_next             = ST_IDLE;
            end
            ST_SCAN: begin
                if (cnt_reg < n_reg) begin
                    nt_re    = 1'b1;
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pv_reg && (e_level > top_reg)) begin
                    top_next = e_level;
                end
                if ((cnt_reg == n_reg) && !pv_reg) begin
                    cnt_next   = '0;
                    lvl_next   = '0;
                    state_next = ST_NRD;
                end
            end
            ST_NRD: begin
                if (cnt_reg < n_reg) begin
                    nt_re      = 1'b1;
                    state_next = ST_NCHK;
                end else if (lvl_reg == top_reg) begin
                    state_next = ST_DONE;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                    cnt_next = '0;
                end
            end
            ST_NCHK: begin
                j_next = '0;
                if (e_level != lvl_reg) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_NRD;
                end else if (e_root) begin
                    state_next = ST_COPY;
                end else begin
                    parent_next = e_parent;
                    state_next  = ST_PLOAD;
                end
            end
            ST_COPY: begin
                if (j_reg < 7'd16) begin
                    lo_re   = 1'b1;
                    pv_next = 1'b1;
                    j_next  = j_reg + 1'b1;
                end
                wo_we = pv_reg;
                if ((j_reg == 7'd16) && !pv_reg) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_NRD;
                end
            end
            ST_PLOAD: begin
                if (j_reg < 7'd16) begin
                    wo_re   = 1'b1;
                    pv_next = 1'b1;
                    j_next  = j_reg + 1'b1;
                end
                if ((j_reg == 7'd16) && !pv_reg) begin
                    j_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                lo_raddr = {cnt_reg[hwt_pkg::NODE_W-1:0], j_reg[1:0], j_reg[3:2]};
                wo_we    = mac_wr.valid;
                wo_waddr = {cnt_reg[hwt_pkg::NODE_W-1:0], mac_wr.elem};
                wo_wdata = mac_wr.data;
                if (j_reg < 7'd64) begin
                    lo_re     = 1'b1;
                    mac_issue = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                if ((j_reg == 7'd64) && !mv_reg && !mac_busy) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_NRD;
                end
            end
            ST_DONE: begin
                m_valid_next           = 1'b1;
                m_data_next.read_value = '0;
                m_data_next.saturated  = sat_reg;
                state_next             = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            m_valid_reg    <= 1'b0;
            pv_reg         <= 1'b0;
            mv_reg         <= 1'b0;
            nt_valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pv_reg      <= pv_next;
            mv_reg      <= mac_issue;
            if (cfg_we) begin
                node_count_reg <= cfg_data;
            end
            if (nt_we) begin
                nt_valid_reg[s_data.node] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        cnt_reg    <= cnt_next;
        top_reg    <= top_next;
        lvl_reg    <= lvl_next;
        j_reg      <= j_next;
        parent_reg <= parent_next;
        sat_reg    <= sat_next;
        m_data_reg <= m_data_next;
        pj_reg     <= j_reg[3:0];
        pidx_reg   <= {j_reg[5:4], j_reg[1:0]};
        me_reg     <= j_reg[5:2];
        mfirst_reg <= (j_reg[1:0] == 2'd0);
        mlast_reg  <= (j_reg[1:0] == 2'd3);
        if (nt_re) begin
            nt_vld_q_reg <= nt_valid_reg[nt_raddr];
        end
        if ((state_reg == ST_PLOAD) && pv_reg) begin
            par_buf[pj_reg] <= wo_rdata;
        end
    end

endmodule
`default_nettype wire

[hdl/hwt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_checker
// Port-level assertions for the world transform update block.
// ----------------------------------------------------------------------------
module hwt_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire hwt_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire hwt_pkg::out_t m_data
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output valid is set after reset.");

    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Output transaction changed while stalled.");

    a_no_accept_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Input accepted while the output is stalled.");

    a_table_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.operation == hwt_pkg::OP_SET_HIER ||
                               s_data.operation == hwt_pkg::OP_WR_LOCAL)
        |=> m_valid && (m_data.read_value == 0) && !m_data.saturated)
        else $error("Table write did not return a zero result on the next cycle.");

endmodule

bind hierarchy_world_transform_update hwt_checker u_hwt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
